// ===== hw/rtl/bep_pkg.sv =====
// Shared types and constants of the exact binomial coefficient core.
package bep_pkg;

	localparam int FIELD_W = 7;                  // width of n and r
	localparam int ACC_W   = 63;                 // width of the running coefficient
	localparam int DIGIT_W = 8;                  // quotient bits formed per divide cycle
	localparam int PROD_W  = 72;                 // product acc * factor, digit aligned
	localparam int DIGITS  = PROD_W / DIGIT_W;   // quotient digits per step
	localparam int DCNT_W  = $clog2(DIGITS);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;   // take a new request
		logic mul;    // form the product of the running value and the factor
		logic div;    // one digit of the exact division
		logic emit;   // copy the result to the output register
	} cmd_t;

	typedef struct packed {
		logic steps_done;   // all factors applied
		logic last_digit;   // the current divide cycle is the final one
	} stat_t;

endpackage

// ===== hw/rtl/bep_ctrl.sv =====
// Sequencer of the exact binomial coefficient core.
module bep_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  bep_pkg::stat_t stat,
	output bep_pkg::cmd_t  cmd
);

	bep_pkg::state_t state_q;
	bep_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign in_stall  = (state_q != bep_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		case (state_q)
			bep_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bep_pkg::ST_CHECK;
				end
			end
			bep_pkg::ST_CHECK: begin
				state_d = stat.steps_done ? bep_pkg::ST_FINISH : bep_pkg::ST_MUL;
			end
			bep_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = bep_pkg::ST_DIV;
			end
			bep_pkg::ST_DIV: begin
				cmd.div = 1'b1;
				if (stat.last_digit) begin
					state_d = bep_pkg::ST_CHECK;
				end
			end
			bep_pkg::ST_FINISH: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = bep_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bep_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bep_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/bep_dpath.sv =====
// Datapath of the exact binomial coefficient core: multiplier and radix-256 divider.
module bep_dpath #(
	parameter int MAX_N = 66
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bep_pkg::cmd_t                cmd,
	output bep_pkg::stat_t               stat,
	input  logic [bep_pkg::FIELD_W-1:0]  n,
	input  logic [bep_pkg::FIELD_W-1:0]  r,
	output logic [bep_pkg::ACC_W-1:0]    value
);

	logic [bep_pkg::PROD_W-1:0]  work_q;   // running value, product, then quotient
	logic [bep_pkg::FIELD_W-1:0] rem_q;    // partial remainder of the division
	logic [bep_pkg::FIELD_W-1:0] m_q;      // factor n-i+1
	logic [bep_pkg::FIELD_W-1:0] i_q;      // divisor i
	logic [bep_pkg::FIELD_W-1:0] k_q;      // number of steps
	logic [bep_pkg::DCNT_W-1:0]  dcnt_q;
	logic [bep_pkg::ACC_W-1:0]   value_q;

	logic                        zero_res;
	logic [bep_pkg::FIELD_W-1:0] n_minus_r;
	logic [bep_pkg::FIELD_W-1:0] k_d;
	logic [bep_pkg::PROD_W-1:0]  prod;
	logic [bep_pkg::DIGIT_W-1:0] qdig;
	logic [bep_pkg::FIELD_W-1:0] rem_d;

	assign zero_res  = (n > bep_pkg::FIELD_W'(MAX_N)) || (r > n);
	assign n_minus_r = n - r;
	// use the symmetric count, it gives the same coefficient in fewer steps
	assign k_d       = zero_res ? '0 : ((r < n_minus_r) ? r : n_minus_r);
	assign prod      = {{(bep_pkg::PROD_W-bep_pkg::ACC_W){1'b0}}, work_q[bep_pkg::ACC_W-1:0]} *
		{{(bep_pkg::PROD_W-bep_pkg::FIELD_W){1'b0}}, m_q};

	// eight restoring steps on the top byte of the dividend
	always_comb begin
		logic [bep_pkg::FIELD_W:0] t;
		t = {1'b0, rem_q};
		for (int b = 0; b < bep_pkg::DIGIT_W; b++) begin
			t = {t[bep_pkg::FIELD_W-1:0], work_q[bep_pkg::PROD_W-1-b]};
			if (t >= {1'b0, i_q}) begin
				t = t - {1'b0, i_q};
				qdig[bep_pkg::DIGIT_W-1-b] = 1'b1;
			end else begin
				qdig[bep_pkg::DIGIT_W-1-b] = 1'b0;
			end
		end
		rem_d = t[bep_pkg::FIELD_W-1:0];
	end

	assign stat.steps_done = (i_q > k_q);
	assign stat.last_digit = (dcnt_q == bep_pkg::DCNT_W'(bep_pkg::DIGITS - 1));
	assign value           = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.mul) begin
			dcnt_q <= '0;
		end else if (cmd.div) begin
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= zero_res ? '0 : bep_pkg::PROD_W'(1);
			m_q    <= n;
			i_q    <= bep_pkg::FIELD_W'(1);
			k_q    <= k_d;
		end else if (cmd.mul) begin
			work_q <= prod;
			rem_q  <= '0;
		end else if (cmd.div) begin
			work_q <= {work_q[bep_pkg::PROD_W-bep_pkg::DIGIT_W-1:0], qdig};
			rem_q  <= rem_d;
			if (stat.last_digit) begin
				i_q <= i_q + 1'b1;
				m_q <= m_q - 1'b1;
			end
		end
		if (cmd.emit) begin
			value_q <= work_q[bep_pkg::ACC_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/binomial_exact_product_core.sv =====
// Top level of the exact binomial coefficient core.
// A request carries n and r on the input channel (in_valid / in_stall). The
// core answers each request with one result, value = n choose r, on the output
// channel (out_valid / out_stall). r = 0 gives 1, r > n gives 0, and n above
// MAX_N gives 0 as an out-of-range mark, even for r = 0.
// The count k = min(r, n-r) of steps is formed at acceptance. Each step passes
// the loop check (ST_CHECK), multiplies the running value by n-i+1 (ST_MUL)
// and divides the 72-bit product exactly by i, eight quotient bits per cycle
// (ST_DIV). Throughput: one request in work at a time, in_stall high while it
// runs; the next request is taken at the earliest in the cycle after the result
// is loaded into the output register.
// Reset: arst_n clears the sequencer and the output valid flag; no result is
// pending after reset.
// Stall: a result waits in the output register while out_stall is high. The
// core accepts the next request meanwhile and holds its own finished result
// until the output register frees up.
module binomial_exact_product_core #(
	parameter int MAX_N = 66
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bep_pkg::FIELD_W-1:0]  n,
	input  logic [bep_pkg::FIELD_W-1:0]  r,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bep_pkg::ACC_W-1:0]    value
);

	bep_pkg::cmd_t  cmd;
	bep_pkg::stat_t stat;

	// sequencer: accept, step loop, emit
	bep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// multiplier, digit divider and output register
	bep_dpath #(
		.MAX_N (MAX_N)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.n      (n),
		.r      (r),
		.value  (value)
	);

endmodule

// ===== verif/binomial_exact_product_checker.sv =====
// Checker that predicts and compares the results of the binomial coefficient core.
module binomial_exact_product_checker #(
	parameter int MAX_N = 66
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [bep_pkg::FIELD_W-1:0]  n,
	input  logic [bep_pkg::FIELD_W-1:0]  r,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [bep_pkg::ACC_W-1:0]    value,
	output int                           mismatches,
	output int                           pending
);

	typedef struct {
		logic [bep_pkg::FIELD_W-1:0] set_n;
		logic [bep_pkg::FIELD_W-1:0] pick_r;
		logic [bep_pkg::ACC_W-1:0]   coeff;
	} coeff_req_t;

	coeff_req_t coeff_q[$];

	// n choose r by the multiplicative rule, exact in 128 bits
	function automatic logic [bep_pkg::ACC_W-1:0] choose_exact(
		logic [bep_pkg::FIELD_W-1:0] set_n,
		logic [bep_pkg::FIELD_W-1:0] pick_r
	);
		logic [127:0] running;
		int step;
		if (set_n > MAX_N || pick_r > set_n)
			return '0;
		running = 128'd1;
		for (step = 1; step <= pick_r; step++)
			running = running * (128'(set_n) - 128'(step) + 128'd1) / 128'(step);
		return running[bep_pkg::ACC_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		coeff_req_t head;
		coeff_req_t fresh;
		if (!arst_n) begin
			coeff_q.delete();
			pending    = 0;
			mismatches = 0;
		end else begin
			// compare first: a result never belongs to a request taken at the same edge
			if (out_valid && !out_stall) begin
				if (coeff_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value=%0d", value);
				end else begin
					head = coeff_q.pop_front();
					if (value !== head.coeff) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch n=%0d r=%0d: expected %0d, got %0d",
								head.set_n, head.pick_r, head.coeff, value);
					end
				end
			end
			if (in_valid && !in_stall) begin
				fresh.set_n  = n;
				fresh.pick_r = r;
				fresh.coeff  = choose_exact(n, r);
				coeff_q.insert(coeff_q.size(), fresh);
			end
			pending = coeff_q.size();
		end
	end

endmodule

// ===== verif/binomial_exact_product_core_tb.sv =====
// Testbench top for the exact binomial coefficient core: stimulus, back-pressure and verdict.
module binomial_exact_product_core_tb;

	localparam int MAX_N        = 66;
	localparam int LATENCY_MAX  = 365;     // wait bound for the longest request (k = 33)
	localparam int HOLD_CYCLES  = 1500;    // long receiver hold-off
	localparam int IDLE_LIMIT   = 20000;   // cycles without any handshake before giving up
	localparam int PHASE_ITEMS  = 200;     // random requests per idling phase

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [bep_pkg::FIELD_W-1:0]  n;
	logic [bep_pkg::FIELD_W-1:0]  r;
	logic                         out_valid;
	logic                         out_stall;
	logic [bep_pkg::ACC_W-1:0]    value;

	int mismatches;
	int pending;
	int src_idle_pct;
	int sink_idle_pct;
	bit sink_hold_go;
	int quiet_cycles;

	binomial_exact_product_core #(
		.MAX_N(MAX_N)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.n         (n),
		.r         (r),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

	binomial_exact_product_checker #(
		.MAX_N(MAX_N)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.n          (n),
		.r          (r),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: stall at random each falling edge; on request, hold off once for a
	// long stretch so the core fills up and stalls its own input.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_go && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < sink_idle_pct);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves anything.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Offer one request. Enter and leave at a falling edge; the caller must drive
	// in_valid at the edge this task returns on, since the accepted request is
	// still presented there.
	task automatic send_request(
		input logic [bep_pkg::FIELD_W-1:0] set_n,
		input logic [bep_pkg::FIELD_W-1:0] pick_r
	);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		n        <= set_n;
		r        <= pick_r;
		// hold the payload until a rising edge sees stall low
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	initial begin
		logic [bep_pkg::FIELD_W-1:0] rnd_n;
		logic [bep_pkg::FIELD_W-1:0] rnd_r;
		int kind;
		int phase;
		int item;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		n             = '0;
		r             = '0;
		src_idle_pct  = 14;
		sink_idle_pct = 85;
		sink_hold_go  = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed requests: field extremes and every special case.
		send_request(7'd0,   7'd0);     // r zero with n zero gives one
		send_request(7'd66,  7'd0);     // r zero at the top of the range
		send_request(7'd127, 7'd0);     // n out of range wins over r zero
		send_request(7'd127, 7'd127);   // both fields all ones
		send_request(7'd66,  7'd33);    // largest coefficient, longest run
		send_request(7'd66,  7'd66);
		send_request(7'd66,  7'd65);
		send_request(7'd66,  7'd1);
		send_request(7'd66,  7'd67);    // r just above n
		send_request(7'd66,  7'd127);   // r far above n
		send_request(7'd67,  7'd1);     // n just above the bound
		send_request(7'd67,  7'd0);
		send_request(7'd0,   7'd1);     // r above n at the bottom
		send_request(7'd1,   7'd1);
		send_request(7'd5,   7'd2);
		send_request(7'd10,  7'd11);
		send_request(7'd64,  7'd32);
		send_request(7'd65,  7'd32);
		send_request(7'd40,  7'd20);
		send_request(7'd100, 7'd50);
		send_request(7'd85,  7'd42);    // alternating bit patterns
		send_request(7'd42,  7'd21);

		// Pause the sender until every expected result is back.
		in_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 14;
					sink_idle_pct = 85;
				end
				1: begin
					src_idle_pct  = 85;
					sink_idle_pct = 14;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase

			for (item = 0; item < PHASE_ITEMS; item++) begin
				// After a few requests of the first phase, hold off the receiver
				// while the sender keeps offering.
				if (phase == 0 && item == 5)
					sink_hold_go = 1'b1;
				kind = $urandom_range(99);
				if (kind < 70) begin
					// well-formed: r within n
					rnd_n = 7'($urandom_range(MAX_N));
					rnd_r = 7'($urandom_range(rnd_n));
				end else if (kind < 80) begin
					// r above n
					rnd_n = 7'($urandom_range(MAX_N));
					rnd_r = 7'($urandom_range(127, rnd_n + 1));
				end else if (kind < 90) begin
					// n out of range
					rnd_n = 7'($urandom_range(127, MAX_N + 1));
					rnd_r = 7'($urandom_range(127));
				end else begin
					rnd_n = 7'($urandom_range(127));
					rnd_r = 7'($urandom_range(127));
				end
				send_request(rnd_n, rnd_r);
			end
		end

		// Drop valid, drain every result, then watch for strays.
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (LATENCY_MAX + 20) @(posedge clk);

		if (mismatches == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== binomial_exact_product_core.f =====
hw/rtl/bep_pkg.sv
hw/rtl/bep_ctrl.sv
hw/rtl/bep_dpath.sv
hw/rtl/binomial_exact_product_core.sv
verif/binomial_exact_product_checker.sv
verif/binomial_exact_product_core_tb.sv
